// File: src/arc_pkg.sv
// Shared types and constants of the ARP resolver cache.
package arc_pkg;

   localparam int CacheEntries = 16;
   localparam int HoldEntries  = 16;
   localparam int QueueDepth   = 16;
   localparam int MaxResults   = 16;

   localparam int MacW    = 48;
   localparam int IpW     = 32;
   localparam int MsW     = 24;
   localparam int HandleW = 16;
   localparam int TimeW   = 48;
   localparam int TypeW   = 16;
   localparam int TickW   = 16;
   localparam int CsrDataW = 48;

   localparam logic [MacW-1:0]  BcastMac      = 48'hFFFF_FFFF_FFFF;
   localparam logic [TypeW-1:0] TypeArp       = 16'h0806;
   localparam logic [TypeW-1:0] TypeIpv4      = 16'h0800;
   localparam logic [15:0]      OpcRequest    = 16'h0001;
   localparam logic [15:0]      OpcReply      = 16'h0002;
   localparam logic [MsW-1:0]   LifetimeReset = 24'd30000;
   localparam logic [MsW-1:0]   HoldReset     = 24'd5000;

   typedef enum logic [1:0] {
      OP_SEND,
      OP_RECV,
      OP_TICK,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      KIND_ARP_REQ,
      KIND_ARP_REPLY,
      KIND_IPV4_OUT,
      KIND_DELIVER,
      KIND_DROP
   } kind_type;

   typedef enum logic [1:0] {
      CSR_OWN_MAC,
      CSR_OWN_IP,
      CSR_LIFETIME,
      CSR_HOLD
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEND_CACHE,
      S_SEND_HIT,
      S_SEND_HOLD,
      S_SEND_REQ,
      S_SEND_QUEUE,
      S_DELIVER,
      S_LEARN_SCAN,
      S_LEARN_WR,
      S_HOLD_CLR,
      S_REPLY,
      S_DRAIN_CHK,
      S_DRAIN_SCAN,
      S_DRAIN_EMIT,
      S_TICK_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [MacW-1:0] own_mac;
      logic [IpW-1:0]  own_ip;
      logic [MsW-1:0]  lifetime;
      logic [MsW-1:0]  hold;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic [MacW-1:0]    mac;
      logic [IpW-1:0]     ip;
      logic [HandleW-1:0] handle;
      logic               last;
   } res_type;

   typedef struct packed {
      logic match;
      logic live;
      logic older;
   } cmp_type;

endpackage

// File: src/arc_csr.sv
// Configuration register file of the ARP resolver cache.
module arc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [arc_pkg::CsrDataW-1:0] csr_data,
   output arc_pkg::cfg_type            cfg
);
   import arc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_OWN_MAC:  cfg_in.own_mac  = csr_data[MacW-1:0];
            CSR_OWN_IP:   cfg_in.own_ip   = csr_data[IpW-1:0];
            CSR_LIFETIME: cfg_in.lifetime = csr_data[MsW-1:0];
            CSR_HOLD:     cfg_in.hold     = csr_data[MsW-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_mac  <= '0;
         cfg_ff.own_ip   <= '0;
         cfg_ff.lifetime <= LifetimeReset;
         cfg_ff.hold     <= HoldReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/arc_cmp.sv
// Shared entry compare unit: address match, expiry liveness, oldest-entry search.
module arc_cmp (
   input  logic                      ent_valid,
   input  logic [arc_pkg::IpW-1:0]   ent_ip,
   input  logic [arc_pkg::IpW-1:0]   key_ip,
   input  logic [arc_pkg::TimeW-1:0] ent_exp,
   input  logic [arc_pkg::TimeW-1:0] now,
   input  logic [arc_pkg::TimeW-1:0] best_exp,
   output arc_pkg::cmp_type          res
);
   import arc_pkg::*;

   always_comb begin
      res.match = ent_valid && (ent_ip == key_ip);
      res.live  = (ent_exp >= now);
      res.older = (ent_exp < best_exp);
   end

endmodule

// File: src/arc_core.sv
// Sequencer, cache, hold table and pending queue of the ARP resolver.
module arc_core #(
   parameter int CACHE_ENTRIES = arc_pkg::CacheEntries,
   parameter int HOLD_ENTRIES  = arc_pkg::HoldEntries,
   parameter int QUEUE_DEPTH   = arc_pkg::QueueDepth
) (
   input  logic                        clock,
   input  logic                        reset,
   input  arc_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [arc_pkg::HandleW-1:0] req_dgram_handle,
   input  logic [arc_pkg::IpW-1:0]     req_next_hop_ip,
   input  logic [arc_pkg::MacW-1:0]    req_frame_dst_mac,
   input  logic [arc_pkg::TypeW-1:0]   req_frame_type,
   input  logic                        req_payload_ok,
   input  logic [15:0]                 req_arp_opcode,
   input  logic [arc_pkg::IpW-1:0]     req_sender_ip,
   input  logic [arc_pkg::MacW-1:0]    req_sender_mac,
   input  logic [arc_pkg::IpW-1:0]     req_target_ip,
   input  logic [arc_pkg::TickW-1:0]   req_elapsed_ms,
   input  logic                        slot_free,
   output logic                        push_valid,
   output arc_pkg::res_type            push_res
);
   import arc_pkg::*;

   localparam int CW   = $clog2(CACHE_ENTRIES);
   localparam int HW   = $clog2(HOLD_ENTRIES);
   localparam int SW   = (CW > HW) ? CW : HW;
   localparam int QW   = $clog2(QUEUE_DEPTH);
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
   localparam int TW   = CNTW + 1;
   localparam int DW   = $clog2(MaxResults + 1);

   // stores
   logic [IpW-1:0]     c_ip_ff  [CACHE_ENTRIES];
   logic [MacW-1:0]    c_mac_ff [CACHE_ENTRIES];
   logic [TimeW-1:0]   c_exp_ff [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] c_val_ff;
   logic [IpW-1:0]     h_ip_ff  [HOLD_ENTRIES];
   logic [TimeW-1:0]   h_exp_ff [HOLD_ENTRIES];
   logic [HOLD_ENTRIES-1:0]  h_val_ff;
   logic [IpW-1:0]     q_ip_ff     [QUEUE_DEPTH];
   logic [HandleW-1:0] q_handle_ff [QUEUE_DEPTH];
   logic [QW-1:0]      head_ff;
   logic [CNTW-1:0]    cnt_ff;
   logic [TimeW-1:0]   now_ff;

   // item and sequencer state
   state_type          state_ff, state_in;
   logic [SW-1:0]      idx_ff;
   logic [IpW-1:0]     key_ip_ff, sip_ff, tip_ff;
   logic [MacW-1:0]    smac_ff;
   logic [HandleW-1:0] handle_ff;
   logic               is_reply_ff;
   logic [DW-1:0]      drained_ff;

   // scan trackers
   logic               m_found_ff, m_found_in, m_live_ff, m_live_in;
   logic [SW-1:0]      m_idx_ff, m_idx_in;
   logic [MacW-1:0]    mac_ff, mac_in;
   logic               f_found_ff, f_found_in;
   logic [SW-1:0]      f_idx_ff, f_idx_in;
   logic [SW-1:0]      b_idx_ff, b_idx_in;
   logic [TimeW-1:0]   b_exp_ff, b_exp_in;

   // staged result, pushed once the next one (or the item end) is known
   res_type            stg_ff;
   logic               stg_valid_ff;

   logic [CW-1:0]      cidx;
   logic [HW-1:0]      hidx;
   logic               use_hold, scan_state, scan_last, first;
   logic               e_valid;
   logic [IpW-1:0]     e_ip;
   logic [TimeW-1:0]   e_exp;
   cmp_type            cr;
   logic [SW-1:0]      slot;
   logic [MsW-1:0]     add_op;
   logic [TimeW:0]     add_sum;
   logic [TimeW-1:0]   add_sat;
   logic [TW-1:0]      tail_sum;
   logic [QW-1:0]      tail;
   logic [QW-1:0]      head_next;
   logic               q_full, dst_ok, arp_go, ipv4_go;
   logic               emit_req, emit_ok, emit_fire;
   res_type            emit_res;

   assign cidx = idx_ff[CW-1:0];
   assign hidx = idx_ff[HW-1:0];
   assign use_hold   = (state_ff == S_SEND_HOLD) || (state_ff == S_HOLD_CLR);
   assign scan_state = (state_ff == S_SEND_CACHE) || (state_ff == S_SEND_HOLD) ||
                       (state_ff == S_LEARN_SCAN) || (state_ff == S_HOLD_CLR) ||
                       (state_ff == S_DRAIN_SCAN) || (state_ff == S_TICK_SCAN);
   assign scan_last  = use_hold ? (idx_ff == SW'(HOLD_ENTRIES - 1))
                                : (idx_ff == SW'(CACHE_ENTRIES - 1));
   assign first      = (idx_ff == '0);

   always_comb begin
      if (use_hold) begin
         e_valid = h_val_ff[hidx];
         e_ip    = h_ip_ff[hidx];
         e_exp   = h_exp_ff[hidx];
      end else begin
         e_valid = c_val_ff[cidx];
         e_ip    = c_ip_ff[cidx];
         e_exp   = c_exp_ff[cidx];
      end
   end

   arc_cmp u_cmp (
      .ent_valid (e_valid),
      .ent_ip    (e_ip),
      .key_ip    (key_ip_ff),
      .ent_exp   (e_exp),
      .now       (now_ff),
      .best_exp  (b_exp_ff),
      .res       (cr)
   );

   // one pass finds the match, the lowest free entry and the earliest expiry
   always_comb begin
      m_found_in = first ? 1'b0 : m_found_ff;
      m_idx_in   = m_idx_ff;
      m_live_in  = m_live_ff;
      mac_in     = mac_ff;
      f_found_in = first ? 1'b0 : f_found_ff;
      f_idx_in   = f_idx_ff;
      b_idx_in   = b_idx_ff;
      b_exp_in   = b_exp_ff;
      if (!m_found_in && cr.match) begin
         m_found_in = 1'b1;
         m_idx_in   = idx_ff;
         m_live_in  = cr.live;
         mac_in     = c_mac_ff[cidx];
      end
      if (!f_found_in && !e_valid) begin
         f_found_in = 1'b1;
         f_idx_in   = idx_ff;
      end
      if (first || (e_valid && cr.older)) begin
         b_idx_in = idx_ff;
         b_exp_in = e_exp;
      end
   end

   assign slot = m_found_ff ? m_idx_ff : (f_found_ff ? f_idx_ff : b_idx_ff);

   // shared saturating time adder
   always_comb begin
      unique case (state_ff)
         S_LEARN_WR: add_op = cfg.lifetime;
         S_SEND_REQ: add_op = cfg.hold;
         default:    add_op = MsW'(req_elapsed_ms);
      endcase
      add_sum = {1'b0, now_ff} + (TimeW + 1)'(add_op);
      add_sat = add_sum[TimeW] ? {TimeW{1'b1}} : add_sum[TimeW-1:0];
   end

   always_comb begin
      tail_sum = TW'(head_ff) + TW'(cnt_ff);
      if (tail_sum >= TW'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - TW'(QUEUE_DEPTH);
      end
      tail      = tail_sum[QW-1:0];
      head_next = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   end

   assign q_full  = (cnt_ff >= CNTW'(QUEUE_DEPTH));
   assign dst_ok  = (req_frame_dst_mac == cfg.own_mac) || (req_frame_dst_mac == BcastMac);
   assign arp_go  = dst_ok && (req_frame_type == TypeArp) && req_payload_ok &&
                    ((req_arp_opcode == OpcRequest) || (req_arp_opcode == OpcReply));
   assign ipv4_go = dst_ok && (req_frame_type == TypeIpv4) && req_payload_ok;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (op_type'(req_op))
                  OP_SEND: state_in = S_SEND_CACHE;
                  OP_RECV: state_in = arp_go ? S_LEARN_SCAN :
                                      (ipv4_go ? S_DELIVER : S_FINISH);
                  OP_TICK: state_in = S_TICK_SCAN;
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_SEND_CACHE: if (scan_last) begin
            state_in = (m_found_in && m_live_in) ? S_SEND_HIT : S_SEND_HOLD;
         end
         S_SEND_HIT:   if (emit_ok) state_in = S_FINISH;
         S_SEND_HOLD:  if (scan_last) begin
            state_in = (m_found_in && m_live_in) ? S_FINISH : S_SEND_REQ;
         end
         S_SEND_REQ:   if (emit_ok) state_in = S_SEND_QUEUE;
         S_SEND_QUEUE: if (!q_full || emit_ok) state_in = S_FINISH;
         S_DELIVER:    if (emit_ok) state_in = S_FINISH;
         S_LEARN_SCAN: if (scan_last) state_in = S_LEARN_WR;
         S_LEARN_WR:   state_in = S_HOLD_CLR;
         S_HOLD_CLR:   if (scan_last) state_in = is_reply_ff ? S_DRAIN_CHK : S_REPLY;
         S_REPLY:      if ((tip_ff != cfg.own_ip) || emit_ok) state_in = S_FINISH;
         S_DRAIN_CHK: begin
            if ((cnt_ff == '0) || (drained_ff == DW'(MaxResults))) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_DRAIN_SCAN;
            end
         end
         S_DRAIN_SCAN: if (scan_last) begin
            state_in = (m_found_in && m_live_in) ? S_DRAIN_EMIT : S_FINISH;
         end
         S_DRAIN_EMIT: if (emit_ok) state_in = S_DRAIN_CHK;
         S_TICK_SCAN:  if (scan_last) state_in = S_FINISH;
         S_FINISH:     if (!stg_valid_ff || slot_free) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      emit_req        = 1'b0;
      emit_res        = '0;
      emit_res.kind   = KIND_IPV4_OUT;
      unique case (state_ff)
         S_SEND_HIT: begin
            emit_req        = 1'b1;
            emit_res.mac    = mac_ff;
            emit_res.handle = handle_ff;
         end
         S_SEND_REQ: begin
            emit_req      = 1'b1;
            emit_res.kind = KIND_ARP_REQ;
            emit_res.mac  = BcastMac;
            emit_res.ip   = key_ip_ff;
         end
         S_SEND_QUEUE: begin
            emit_req        = q_full;
            emit_res.kind   = KIND_DROP;
            emit_res.handle = handle_ff;
         end
         S_DELIVER: begin
            emit_req        = 1'b1;
            emit_res.kind   = KIND_DELIVER;
            emit_res.handle = handle_ff;
         end
         S_REPLY: begin
            emit_req      = (tip_ff == cfg.own_ip);
            emit_res.kind = KIND_ARP_REPLY;
            emit_res.mac  = smac_ff;
            emit_res.ip   = sip_ff;
         end
         S_DRAIN_EMIT: begin
            emit_req        = 1'b1;
            emit_res.mac    = mac_ff;
            emit_res.handle = q_handle_ff[head_ff];
         end
         default: emit_req = 1'b0;
      endcase
   end

   assign emit_ok   = !stg_valid_ff || slot_free;
   assign emit_fire = emit_req && emit_ok;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      push_valid    = stg_valid_ff && slot_free &&
                      (emit_req || (state_ff == S_FINISH));
      push_res      = stg_ff;
      push_res.last = (state_ff == S_FINISH);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         c_val_ff     <= '0;
         h_val_ff     <= '0;
         head_ff      <= '0;
         cnt_ff       <= '0;
         now_ff       <= '0;
         drained_ff   <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= (scan_state && !scan_last) ? idx_ff + 1'b1 : '0;
         if (req_valid && req_ready) begin
            drained_ff <= '0;
            if (req_op == OP_TICK) now_ff <= add_sat;
         end
         if (state_ff == S_LEARN_WR) c_val_ff[slot[CW-1:0]] <= 1'b1;
         if ((state_ff == S_TICK_SCAN) && e_valid && !cr.live) c_val_ff[cidx] <= 1'b0;
         if ((state_ff == S_SEND_REQ) && emit_ok) h_val_ff[slot[HW-1:0]] <= 1'b1;
         if ((state_ff == S_HOLD_CLR) && cr.match) h_val_ff[hidx] <= 1'b0;
         if ((state_ff == S_SEND_QUEUE) && !q_full) cnt_ff <= cnt_ff + 1'b1;
         if ((state_ff == S_DRAIN_EMIT) && emit_ok) begin
            head_ff    <= head_next;
            cnt_ff     <= cnt_ff - 1'b1;
            drained_ff <= drained_ff + 1'b1;
         end
         if (emit_fire) begin
            stg_valid_ff <= 1'b1;
         end else if ((state_ff == S_FINISH) && slot_free) begin
            stg_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         key_ip_ff   <= (req_op == OP_SEND) ? req_next_hop_ip : req_sender_ip;
         sip_ff      <= req_sender_ip;
         tip_ff      <= req_target_ip;
         smac_ff     <= req_sender_mac;
         handle_ff   <= req_dgram_handle;
         is_reply_ff <= (req_arp_opcode == OpcReply);
      end
      if (state_ff == S_DRAIN_CHK) key_ip_ff <= q_ip_ff[head_ff];
      if (scan_state) begin
         m_found_ff <= m_found_in;
         m_idx_ff   <= m_idx_in;
         m_live_ff  <= m_live_in;
         mac_ff     <= mac_in;
         f_found_ff <= f_found_in;
         f_idx_ff   <= f_idx_in;
         b_idx_ff   <= b_idx_in;
         b_exp_ff   <= b_exp_in;
      end
      if (state_ff == S_LEARN_WR) begin
         c_ip_ff[slot[CW-1:0]]  <= key_ip_ff;
         c_mac_ff[slot[CW-1:0]] <= smac_ff;
         c_exp_ff[slot[CW-1:0]] <= add_sat;
      end
      if ((state_ff == S_SEND_REQ) && emit_ok) begin
         h_ip_ff[slot[HW-1:0]]  <= key_ip_ff;
         h_exp_ff[slot[HW-1:0]] <= add_sat;
      end
      if ((state_ff == S_SEND_QUEUE) && !q_full) begin
         q_ip_ff[tail]     <= key_ip_ff;
         q_handle_ff[tail] <= handle_ff;
      end
      if (emit_fire) stg_ff <= emit_res;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(QUEUE_DEPTH))
      else $error("pending queue count beyond depth");

   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      drained_ff <= DW'(MaxResults))
      else $error("drain ran past the result limit");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_res.last) |=> (state_ff == S_IDLE))
      else $error("last transfer did not end the item");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a new item while busy");

endmodule

// File: src/arp_resolver_cache.sv
// A send scans the cache and then, unless it holds a live entry, the hold table.
// A received ARP frame scans the cache and then the hold table, plus a cache scan for
// each datagram a reply drains; a tick scans the cache once.
// Throughput: one item at a time, set by the single compare unit stepping one entry a cycle.
// Reset is synchronous and active high: empties the cache, hold table and queue, zeroes time.
// Results leave through an output register, so a stalled consumer only holds the sequencer.
module arp_resolver_cache #(
   parameter int CACHE_ENTRIES = arc_pkg::CacheEntries,
   parameter int HOLD_ENTRIES  = arc_pkg::HoldEntries,
   parameter int QUEUE_DEPTH   = arc_pkg::QueueDepth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [arc_pkg::CsrDataW-1:0] csr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic [arc_pkg::HandleW-1:0]  req_dgram_handle,
   input  logic [arc_pkg::IpW-1:0]      req_next_hop_ip,
   input  logic [arc_pkg::MacW-1:0]     req_frame_dst_mac,
   input  logic [arc_pkg::TypeW-1:0]    req_frame_type,
   input  logic                         req_payload_ok,
   input  logic [15:0]                  req_arp_opcode,
   input  logic [arc_pkg::IpW-1:0]      req_sender_ip,
   input  logic [arc_pkg::MacW-1:0]     req_sender_mac,
   input  logic [arc_pkg::IpW-1:0]      req_target_ip,
   input  logic [arc_pkg::TickW-1:0]    req_elapsed_ms,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_frame_kind,
   output logic [arc_pkg::MacW-1:0]     rsp_out_dst_mac,
   output logic [arc_pkg::IpW-1:0]      rsp_arp_target_addr,
   output logic [arc_pkg::HandleW-1:0]  rsp_out_handle,
   output logic                         rsp_last
);
   import arc_pkg::*;

   cfg_type cfg;
   res_type push_res;
   res_type rsp_ff;
   logic    rsp_valid_ff;
   logic    push_valid;
   logic    slot_free;

   arc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   arc_core #(
      .CACHE_ENTRIES (CACHE_ENTRIES),
      .HOLD_ENTRIES  (HOLD_ENTRIES),
      .QUEUE_DEPTH   (QUEUE_DEPTH)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_dgram_handle  (req_dgram_handle),
      .req_next_hop_ip   (req_next_hop_ip),
      .req_frame_dst_mac (req_frame_dst_mac),
      .req_frame_type    (req_frame_type),
      .req_payload_ok    (req_payload_ok),
      .req_arp_opcode    (req_arp_opcode),
      .req_sender_ip     (req_sender_ip),
      .req_sender_mac    (req_sender_mac),
      .req_target_ip     (req_target_ip),
      .req_elapsed_ms    (req_elapsed_ms),
      .slot_free         (slot_free),
      .push_valid        (push_valid),
      .push_res          (push_res)
   );

   // the register can take a new result when empty or emptied this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) rsp_ff <= push_res;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_kind      = rsp_ff.kind;
   assign rsp_out_dst_mac     = rsp_ff.mac;
   assign rsp_arp_target_addr = rsp_ff.ip;
   assign rsp_out_handle      = rsp_ff.handle;
   assign rsp_last            = rsp_ff.last;

endmodule

// File: sim/arp_resolver_cache_test.sv
// Self-checking testbench for the ARP resolver cache: random and directed traffic against a scoreboard.
module arp_resolver_cache_test;
   import arc_pkg::*;

   typedef struct {
      op_type             op;
      logic [HandleW-1:0] handle;
      logic [IpW-1:0]     hop_ip;
      logic [MacW-1:0]    dst_mac;
      logic [TypeW-1:0]   ftype;
      logic               ok;
      logic [15:0]        opcode;
      logic [IpW-1:0]     sip;
      logic [MacW-1:0]    smac;
      logic [IpW-1:0]     tip;
      logic [TickW-1:0]   elapsed;
   } arp_item_type;

   class arp_scoreboard;
      logic [MacW-1:0]  own_mac;
      logic [IpW-1:0]   own_ip;
      logic [MsW-1:0]   lifetime;
      logic [MsW-1:0]   hold_ms;
      logic [TimeW-1:0] now_ms;
      bit               cache_vld[CacheEntries];
      logic [IpW-1:0]   cache_ip[CacheEntries];
      logic [MacW-1:0]  cache_mac[CacheEntries];
      logic [TimeW-1:0] cache_exp[CacheEntries];
      bit               hold_vld[HoldEntries];
      logic [IpW-1:0]   hold_ip[HoldEntries];
      logic [TimeW-1:0] hold_exp[HoldEntries];
      logic [IpW-1:0]   pend_ip[QueueDepth];
      logic [HandleW-1:0] pend_handle[QueueDepth];
      int               pend_head;
      int               pend_count;
      res_type          frames_due[$];
      res_type          item_frames[$];
      int               errors;
      int               checked;

      function new();
         own_mac = '0;
         own_ip = '0;
         lifetime = LifetimeReset;
         hold_ms = HoldReset;
         now_ms = '0;
         foreach (cache_vld[i]) cache_vld[i] = 0;
         foreach (hold_vld[i]) hold_vld[i] = 0;
         pend_head = 0;
         pend_count = 0;
         errors = 0;
         checked = 0;
      endfunction

      function void write_csr(csr_index_type idx, logic [CsrDataW-1:0] val);
         case (idx)
            CSR_OWN_MAC: own_mac = val;
            CSR_OWN_IP:  own_ip = val[IpW-1:0];
            CSR_LIFETIME: lifetime = val[MsW-1:0];
            CSR_HOLD:    hold_ms = val[MsW-1:0];
            default: ;
         endcase
      endfunction

      function logic [TimeW-1:0] add_sat(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
         logic [TimeW:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
      endfunction

      function int pick(bit v[], logic [IpW-1:0] ips[], logic [TimeW-1:0] ex[],
                        logic [IpW-1:0] ip);
         int best;
         best = 0;
         foreach (v[i]) if (v[i] && ips[i] == ip) return i;
         foreach (v[i]) if (!v[i]) return i;
         foreach (v[i]) if (ex[i] < ex[best]) best = i;
         return best;
      endfunction

      function bit lookup(logic [IpW-1:0] ip, output logic [MacW-1:0] mac);
         mac = '0;
         foreach (cache_vld[i])
            if (cache_vld[i] && cache_ip[i] == ip && cache_exp[i] >= now_ms) begin
               mac = cache_mac[i];
               return 1;
            end
         return 0;
      endfunction

      function void learn(logic [IpW-1:0] ip, logic [MacW-1:0] mac);
         int s;
         s = pick(cache_vld, cache_ip, cache_exp, ip);
         cache_vld[s] = 1;
         cache_ip[s] = ip;
         cache_mac[s] = mac;
         cache_exp[s] = add_sat(now_ms, TimeW'(lifetime));
         foreach (hold_vld[i]) if (hold_vld[i] && hold_ip[i] == ip) hold_vld[i] = 0;
      endfunction

      function void emit(kind_type kind, logic [MacW-1:0] mac, logic [IpW-1:0] ip,
                         logic [HandleW-1:0] handle);
         res_type r;
         if (item_frames.size() >= MaxResults) return;
         r.kind = kind;
         r.mac = mac;
         r.ip = ip;
         r.handle = handle;
         r.last = 0;
         item_frames.push_back(r);
      endfunction

      function void resolve_send(logic [IpW-1:0] ip, logic [HandleW-1:0] handle);
         logic [MacW-1:0] mac;
         int s;
         if (lookup(ip, mac)) begin
            emit(KIND_IPV4_OUT, mac, '0, handle);
            return;
         end
         foreach (hold_vld[i])
            if (hold_vld[i] && hold_ip[i] == ip && hold_exp[i] >= now_ms) return;
         emit(KIND_ARP_REQ, BcastMac, ip, '0);
         s = pick(hold_vld, hold_ip, hold_exp, ip);
         hold_vld[s] = 1;
         hold_ip[s] = ip;
         hold_exp[s] = add_sat(now_ms, TimeW'(hold_ms));
         if (pend_count < QueueDepth) begin
            s = (pend_head + pend_count) % QueueDepth;
            pend_ip[s] = ip;
            pend_handle[s] = handle;
            pend_count++;
         end else begin
            emit(KIND_DROP, '0, '0, handle);
         end
      endfunction

      function void take_frame(arp_item_type it);
         logic [MacW-1:0] mac;
         if (it.dst_mac != own_mac && it.dst_mac != BcastMac) return;
         if (it.ftype == TypeArp) begin
            if (!it.ok) return;
            if (it.opcode == OpcReply) begin
               learn(it.sip, it.smac);
               while (pend_count > 0 && item_frames.size() < MaxResults) begin
                  if (!lookup(pend_ip[pend_head], mac)) break;
                  emit(KIND_IPV4_OUT, mac, '0, pend_handle[pend_head]);
                  pend_head = (pend_head + 1) % QueueDepth;
                  pend_count--;
               end
            end else if (it.opcode == OpcRequest) begin
               learn(it.sip, it.smac);
               if (it.tip == own_ip) emit(KIND_ARP_REPLY, it.smac, it.sip, '0);
            end
         end else if (it.ftype == TypeIpv4) begin
            if (it.ok) emit(KIND_DELIVER, '0, '0, it.handle);
         end
      endfunction

      // Predict the frames caused by one accepted item and queue them.
      function void note_item(arp_item_type it);
         item_frames.delete();
         case (it.op)
            OP_SEND: resolve_send(it.hop_ip, it.handle);
            OP_RECV: take_frame(it);
            OP_TICK: begin
               now_ms = add_sat(now_ms, TimeW'(it.elapsed));
               foreach (cache_vld[i])
                  if (cache_vld[i] && cache_exp[i] < now_ms) cache_vld[i] = 0;
            end
            default: ;
         endcase
         if (item_frames.size() > 0) item_frames[item_frames.size()-1].last = 1;
         foreach (item_frames[i]) frames_due.push_back(item_frames[i]);
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_frame(res_type got);
         res_type want;
         checked++;
         if (frames_due.size() == 0) begin
            report($sformatf("unexpected frame kind=%0d handle=%h", got.kind, got.handle));
            return;
         end
         want = frames_due.pop_front();
         if (got.kind != want.kind || got.mac != want.mac || got.ip != want.ip ||
             got.handle != want.handle || got.last != want.last)
            report($sformatf("got k=%0d mac=%h ip=%h h=%h l=%b want k=%0d mac=%h ip=%h h=%h l=%b",
                             got.kind, got.mac, got.ip, got.handle, got.last,
                             want.kind, want.mac, want.ip, want.handle, want.last));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_data = '0;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_op = '0;
   logic [HandleW-1:0] req_dgram_handle = '0;
   logic [IpW-1:0] req_next_hop_ip = '0;
   logic [MacW-1:0] req_frame_dst_mac = '0;
   logic [TypeW-1:0] req_frame_type = '0;
   logic req_payload_ok = 0;
   logic [15:0] req_arp_opcode = '0;
   logic [IpW-1:0] req_sender_ip = '0;
   logic [MacW-1:0] req_sender_mac = '0;
   logic [IpW-1:0] req_target_ip = '0;
   logic [TickW-1:0] req_elapsed_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [2:0] rsp_frame_kind;
   logic [MacW-1:0] rsp_out_dst_mac;
   logic [IpW-1:0] rsp_arp_target_addr;
   logic [HandleW-1:0] rsp_out_handle;
   logic rsp_last;

   arp_scoreboard sb = new();
   int items_sent = 0;
   int burst_left = 1;

   arp_resolver_cache dut (.*);

   always #4 clock = ~clock;

   // Receiver: alternate ready and stall stretches of random length.
   bit ready_level = 0;
   int ready_cnt = 0;
   always @(posedge clock) begin
      if (ready_cnt == 0) begin
         ready_level = !ready_level;
         ready_cnt = ready_level ? $urandom_range(1, 40) : $urandom_range(1, 12);
      end
      ready_cnt--;
      rsp_ready <= ready_level;
   end

   always @(posedge clock) begin
      res_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         r.kind = kind_type'(rsp_frame_kind);
         r.mac = rsp_out_dst_mac;
         r.ip = rsp_arp_target_addr;
         r.handle = rsp_out_handle;
         r.last = rsp_last;
         sb.check_frame(r);
      end
   end

   task drive_item(arp_item_type it);
      req_valid <= 1;
      req_op <= it.op;
      req_dgram_handle <= it.handle;
      req_next_hop_ip <= it.hop_ip;
      req_frame_dst_mac <= it.dst_mac;
      req_frame_type <= it.ftype;
      req_payload_ok <= it.ok;
      req_arp_opcode <= it.opcode;
      req_sender_ip <= it.sip;
      req_sender_mac <= it.smac;
      req_target_ip <= it.tip;
      req_elapsed_ms <= it.elapsed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(it);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(1, 8);
      end
   endtask

   // Drain all expected frames, then let in-flight silent work finish.
   task settle();
      req_valid <= 0;
      while (sb.frames_due.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task write_csr(csr_index_type idx, logic [CsrDataW-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_csr(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function arp_item_type blank_item(op_type op);
      arp_item_type it;
      it.op = op;
      it.handle = HandleW'($urandom);
      it.hop_ip = '0;
      it.dst_mac = sb.own_mac;
      it.ftype = TypeArp;
      it.ok = 1;
      it.opcode = OpcReply;
      it.sip = '0;
      it.smac = MacW'({$urandom, $urandom});
      it.tip = '0;
      it.elapsed = '0;
      return it;
   endfunction

   function logic [IpW-1:0] pool_ip();
      if ($urandom_range(0, 19) == 0) return $urandom;
      return 32'h0A00_0000 + $urandom_range(0, 19);
   endfunction

   function arp_item_type rand_item();
      arp_item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      it = blank_item(OP_SEND);
      it.hop_ip = pool_ip();
      it.sip = pool_ip();
      it.tip = ($urandom_range(0, 2) == 0) ? sb.own_ip : pool_ip();
      it.dst_mac = ($urandom_range(0, 1) == 0) ? BcastMac : sb.own_mac;
      if (pick < 40) begin
         it.op = OP_SEND;
      end else if (pick < 55) begin
         it.op = OP_RECV;
      end else if (pick < 65) begin
         it.op = OP_RECV;
         it.opcode = OpcRequest;
      end else if (pick < 72) begin
         it.op = OP_RECV;
         it.ftype = TypeIpv4;
         it.ok = 1'($urandom);
      end else if (pick < 80) begin
         // broken frames: bad header, parse error or odd opcode
         it.op = OP_RECV;
         it.dst_mac = ($urandom_range(0, 1) == 0) ? MacW'({$urandom, $urandom}) : it.dst_mac;
         it.ftype = ($urandom_range(0, 1) == 0) ? TypeArp : TypeW'($urandom);
         it.ok = 1'($urandom);
         it.opcode = 16'($urandom);
      end else if (pick < 96) begin
         it.op = OP_TICK;
         pick = $urandom_range(0, 9);
         it.elapsed = (pick < 7) ? TickW'($urandom_range(0, 3000)) :
                      (pick < 8 ? 16'hFFFF : TickW'($urandom));
      end else begin
         it.op = OP_NONE;
         it.elapsed = TickW'($urandom);
         it.hop_ip = $urandom;
      end
      return it;
   endfunction

   task directed();
      arp_item_type it;
      logic [IpW-1:0] ip_a;
      ip_a = 32'h0A00_0001;
      it = blank_item(OP_SEND); it.hop_ip = ip_a; drive_item(it);
      it = blank_item(OP_SEND); it.hop_ip = ip_a; drive_item(it);
      it = blank_item(OP_RECV); it.sip = ip_a; drive_item(it);
      it = blank_item(OP_SEND); it.hop_ip = ip_a; drive_item(it);
      it = blank_item(OP_RECV); it.opcode = OpcRequest; it.sip = 32'h0A00_0002;
      it.tip = sb.own_ip; it.dst_mac = BcastMac; drive_item(it);
      it = blank_item(OP_RECV); it.opcode = OpcRequest; it.sip = 32'h0A00_0003;
      it.tip = 32'h0A00_0009; drive_item(it);
      it = blank_item(OP_RECV); it.ftype = TypeIpv4; drive_item(it);
      it = blank_item(OP_RECV); it.ftype = TypeIpv4; it.ok = 0; drive_item(it);
      it = blank_item(OP_RECV); it.ok = 0; it.sip = 32'h0A00_0004; drive_item(it);
      it = blank_item(OP_RECV); it.opcode = 16'h0003; it.sip = 32'h0A00_0004; drive_item(it);
      it = blank_item(OP_RECV); it.dst_mac = 48'h0000_0000_0BAD; drive_item(it);
      it = blank_item(OP_RECV); it.ftype = 16'h86DD; drive_item(it);
      it = blank_item(OP_NONE); it.hop_ip = ip_a; drive_item(it);
      it = blank_item(OP_TICK); it.elapsed = 16'hFFFF; drive_item(it);
      it = blank_item(OP_TICK); it.elapsed = 16'h0000; drive_item(it);
      // fill the queue behind A, then overflow it
      for (int i = 0; i < 16; i++) begin
         it = blank_item(OP_SEND);
         it.hop_ip = (i == 0) ? ip_a : 32'hC0A8_0000 + i;
         drive_item(it);
      end
      it = blank_item(OP_SEND); it.hop_ip = 32'hC0A8_00FF; drive_item(it);
      it = blank_item(OP_RECV); it.sip = ip_a; drive_item(it);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int phase = 0; phase < 4; phase++) begin
         if (phase > 0) settle();
         case (phase)
            0: begin
               write_csr(CSR_OWN_MAC, 48'h0200_0000_0001);
               write_csr(CSR_OWN_IP, 48'h0A00_00FE);
               write_csr(CSR_LIFETIME, 48'd30000);
               write_csr(CSR_HOLD, 48'd5000);
            end
            1: begin
               write_csr(CSR_OWN_MAC, '0);
               write_csr(CSR_OWN_IP, '0);
               write_csr(CSR_LIFETIME, '0);
               write_csr(CSR_HOLD, '0);
            end
            2: begin
               write_csr(CSR_OWN_MAC, '1);
               write_csr(CSR_OWN_IP, '1);
               write_csr(CSR_LIFETIME, '1);
               write_csr(CSR_HOLD, '1);
            end
            default: begin
               write_csr(CSR_OWN_MAC, CsrDataW'({$urandom, $urandom}));
               write_csr(CSR_OWN_IP, CsrDataW'(32'h0A00_0000 + $urandom_range(0, 19)));
               write_csr(CSR_LIFETIME, CsrDataW'($urandom_range(100, 5000)));
               write_csr(CSR_HOLD, CsrDataW'($urandom_range(0, 2000)));
            end
         endcase
         @(posedge clock);
         if (phase == 0) directed();
         for (int n = 0; n < 17; n++) drive_item(rand_item());
      end
      settle();
      $display("covered %0d items and %0d result frames over four register settings",
               items_sent, sb.checked);
      if (sb.errors == 0 && sb.frames_due.size() == 0) begin
         $display("status: pass");
      end else begin
         if (sb.frames_due.size() != 0)
            sb.report($sformatf("%0d frames never arrived", sb.frames_due.size()));
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("timeout with %0d frames outstanding", sb.frames_due.size());
      $display("status: fail");
      $finish;
   end

endmodule
